[src/rope_pkg.sv]
// Shared types, constants and the rounding helper for the rotary position
// embedding block. No dependencies; every other file imports this package.
package rope_pkg;

  // Data path sizing
  localparam int DATA_WIDTH      = 16;
  localparam int TRIG_WIDTH      = 16;
  localparam int TRIG_FRAC_BITS  = 14;
  localparam int MAX_HEAD_DIM    = 256;
  localparam int SLOT_COUNT      = MAX_HEAD_DIM / 2;
  localparam int SLOT_WIDTH      = $clog2(SLOT_COUNT);
  localparam int POS_WIDTH       = $clog2(MAX_HEAD_DIM);
  localparam int INDEX_WIDTH     = 8;
  localparam int DIM_WIDTH       = 9;
  localparam int PROD_WIDTH      = DATA_WIDTH + TRIG_WIDTH;
  localparam int SUM_WIDTH       = PROD_WIDTH + 1;
  localparam int QUOT_WIDTH      = SUM_WIDTH - TRIG_FRAC_BITS + 1;

  // Result queue sizing (entries hold one rotated pair each)
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_WIDTH  = $clog2(FIFO_DEPTH);
  localparam int COUNT_WIDTH     = $clog2(FIFO_DEPTH + 1);
  localparam int CREDIT_WIDTH    = COUNT_WIDTH + 1;

  // Configuration port
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 9;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HEAD_DIM  = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PAIR_MODE = CFG_INDEX_WIDTH'(1);
  localparam logic [DIM_WIDTH-1:0] HEAD_DIM_RESET = DIM_WIDTH'(128);
  localparam logic [DIM_WIDTH-1:0] HEAD_DIM_MIN   = DIM_WIDTH'(2);
  localparam logic [DIM_WIDTH-1:0] HEAD_DIM_MAX   = DIM_WIDTH'(MAX_HEAD_DIM);

  // Saturation bounds for the rounded quotient
  localparam logic signed [QUOT_WIDTH-1:0] SAT_HI = QUOT_WIDTH'(2 ** (DATA_WIDTH - 1) - 1);
  localparam logic signed [QUOT_WIDTH-1:0] SAT_LO = QUOT_WIDTH'(-(2 ** (DATA_WIDTH - 1)));
  localparam logic [TRIG_FRAC_BITS-1:0] ROUND_HALF = TRIG_FRAC_BITS'(2 ** (TRIG_FRAC_BITS - 1));

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] x_value;
    logic signed [TRIG_WIDTH-1:0] sin_value;
    logic signed [TRIG_WIDTH-1:0] cos_value;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0]       out_index;
    logic signed [DATA_WIDTH-1:0] out_value;
    logic                         row_end;
  } out_item_t;

  typedef struct packed {
    logic                      write;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [CFG_DATA_WIDTH-1:0]  data;
  } cfg_wr_t;

  // Pair bookkeeping that travels alongside the operands
  typedef struct packed {
    logic                 valid;
    logic [POS_WIDTH-1:0] first_idx;
    logic [POS_WIDTH-1:0] second_idx;
    logic                 row_end;
  } pair_ctl_t;

  typedef struct packed {
    out_item_t first_res;
    out_item_t second_res;
  } result_pair_t;

  // Shift right by the fraction bits, round half to even, saturate
  function automatic logic signed [DATA_WIDTH-1:0] round_sat(
    input logic signed [SUM_WIDTH-1:0] v
  );
    logic signed [QUOT_WIDTH-1:0] q;
    logic [TRIG_FRAC_BITS-1:0]    rem;
    logic                         up;
    q   = QUOT_WIDTH'(v >>> TRIG_FRAC_BITS);
    rem = v[TRIG_FRAC_BITS-1:0];
    up  = (rem > ROUND_HALF) || ((rem == ROUND_HALF) && q[0]);
    q   = q + $signed({{(QUOT_WIDTH-1){1'b0}}, up});
    if (q > SAT_HI) begin
      round_sat = DATA_WIDTH'(SAT_HI);
    end else if (q < SAT_LO) begin
      round_sat = DATA_WIDTH'(SAT_LO);
    end else begin
      round_sat = DATA_WIDTH'(q);
    end
  endfunction

endpackage

[src/rotary_position_embedding_top.sv]
// Top level of the rotary position embedding block.
// Depends on rope_pkg, rope_pair_store, rope_rotate and rope_out_fifo.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one head vector element
//   per item with the sine and cosine of its pair, in element order.
//   Output channel (out_valid/out_ready/out_data) gives rotated elements with
//   their index; row_end marks the last result of a head vector.
//   Configuration (cfg_write/cfg_index/cfg_data) sets head_dim (index 0) and
//   pair_mode (index 1); any write restarts the element position at zero.
// Path: a second member is registered with its partner in rope_pair_store,
//   its products are registered in rope_rotate, then the pair is queued and
//   offered as the first result followed by the other.
// Throughput: one item per cycle while in_ready is high; the output side moves
//   one result per cycle while out_ready is high, so in half-split mode the
//   second half of a vector is paced by draining two results per pair.
// Reset clears configuration to head_dim 128, interleaved, and empties the
//   pipeline and result queue; the first-member memory is not cleared.
// When the receiver stalls, results wait in a four-pair queue and in_ready
//   drops once queued and in-flight pairs fill it.
module rotary_position_embedding_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rope_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rope_pkg::out_item_t out_data,
  input  logic                cfg_write,
  input  logic [rope_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [rope_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
  import rope_pkg::*;

  cfg_wr_t                      cfg;
  logic                         accept;
  pair_ctl_t                    s1_ctl;
  logic signed [DATA_WIDTH-1:0] s1_a;
  logic signed [DATA_WIDTH-1:0] s1_x;
  logic signed [TRIG_WIDTH-1:0] s1_sin;
  logic signed [TRIG_WIDTH-1:0] s1_cos;
  logic                         res_valid;
  result_pair_t                 res;
  logic [COUNT_WIDTH-1:0]       fifo_count;
  logic [CREDIT_WIDTH-1:0]      credits_used;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Admit an item only while every pair in flight has a queue slot
  assign credits_used = CREDIT_WIDTH'(fifo_count) + CREDIT_WIDTH'(s1_ctl.valid)
                      + CREDIT_WIDTH'(res_valid);
  assign in_ready     = (credits_used < CREDIT_WIDTH'(FIFO_DEPTH));
  assign accept       = in_valid && in_ready;

  rope_pair_store u_store (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .item   (in_data),
    .s1_ctl (s1_ctl),
    .s1_a   (s1_a),
    .s1_x   (s1_x),
    .s1_sin (s1_sin),
    .s1_cos (s1_cos)
  );

  rope_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .s1_ctl    (s1_ctl),
    .s1_a      (s1_a),
    .s1_x      (s1_x),
    .s1_sin    (s1_sin),
    .s1_cos    (s1_cos),
    .res_valid (res_valid),
    .res       (res)
  );

  rope_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (fifo_count)
  );

endmodule

[src/rope_pair_store.sv]
// Configuration registers, element counter and the first-member memory.
// Depends on rope_pkg. Emits second members with their buffered partner.
module rope_pair_store (
  input  logic               clk,
  input  logic               rst,
  input  rope_pkg::cfg_wr_t  cfg,
  input  logic               accept,
  input  rope_pkg::in_item_t item,
  output rope_pkg::pair_ctl_t s1_ctl,
  output logic signed [rope_pkg::DATA_WIDTH-1:0] s1_a,
  output logic signed [rope_pkg::DATA_WIDTH-1:0] s1_x,
  output logic signed [rope_pkg::TRIG_WIDTH-1:0] s1_sin,
  output logic signed [rope_pkg::TRIG_WIDTH-1:0] s1_cos
);
  import rope_pkg::*;

  logic [DIM_WIDTH-1:0]  head_dim;
  logic                  pair_mode;
  logic [POS_WIDTH-1:0]  counter;
  logic [POS_WIDTH-1:0]  counter_next;

  logic [DIM_WIDTH-1:0]  hd;
  logic [DIM_WIDTH-1:0]  hd_masked;
  logic [DIM_WIDTH-1:0]  half;
  logic [POS_WIDTH-1:0]  c;
  logic [DIM_WIDTH-1:0]  c_ext;
  logic [DIM_WIDTH-1:0]  c_inc;
  logic                  second;
  logic [POS_WIDTH-1:0]  first_idx;
  logic [SLOT_WIDTH-1:0] slot;

  logic signed [DATA_WIDTH-1:0] mem [SLOT_COUNT];

  // Clamp the programmed length: even, at least two, at most the store size
  always_comb begin
    hd_masked = {head_dim[DIM_WIDTH-1:1], 1'b0};
    if (hd_masked < HEAD_DIM_MIN) begin
      hd = HEAD_DIM_MIN;
    end else if (hd_masked > HEAD_DIM_MAX) begin
      hd = HEAD_DIM_MAX;
    end else begin
      hd = hd_masked;
    end
    half = hd >> 1;
  end

  // Decide pair role, partner index and memory slot for this element
  always_comb begin
    c     = (DIM_WIDTH'(counter) >= hd) ? '0 : counter;
    c_ext = DIM_WIDTH'(c);
    c_inc = c_ext + DIM_WIDTH'(1);
    if (pair_mode) begin
      second    = (c_ext >= half);
      first_idx = second ? POS_WIDTH'(c_ext - half) : c;
      slot      = SLOT_WIDTH'(first_idx);
    end else begin
      second    = c[0];
      first_idx = {c[POS_WIDTH-1:1], 1'b0};
      slot      = SLOT_WIDTH'(first_idx >> 1);
    end
    counter_next = (c_inc >= hd) ? '0 : POS_WIDTH'(c_inc);
  end

  // Hold configuration and advance the element position
  always_ff @(posedge clk) begin
    if (rst) begin
      head_dim  <= HEAD_DIM_RESET;
      pair_mode <= 1'b0;
      counter   <= '0;
    end else if (cfg.write) begin
      unique case (cfg.index)
        REG_HEAD_DIM:  head_dim  <= DIM_WIDTH'(cfg.data);
        REG_PAIR_MODE: pair_mode <= cfg.data[0];
        default: ;
      endcase
      counter <= '0;
    end else if (accept) begin
      counter <= counter_next;
    end
  end

  // Store first members, read the partner for second members. A partner
  // written by an earlier accept is already in the array when its second
  // member reads it, so interleaved write-then-read needs no bypass.
  always_ff @(posedge clk) begin
    if (accept && !second) begin
      mem[slot] <= item.x_value;
    end
    if (accept && second) begin
      s1_a <= mem[slot];
    end
  end

  // Carry the second member's operands next to the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl.valid <= 1'b0;
    end else begin
      s1_ctl.valid <= accept && second;
    end
    if (accept && second) begin
      s1_ctl.first_idx  <= first_idx;
      s1_ctl.second_idx <= c;
      s1_ctl.row_end    <= (c_ext == hd - DIM_WIDTH'(1));
      s1_x              <= item.x_value;
      s1_sin            <= item.sin_value;
      s1_cos            <= item.cos_value;
    end
  end

endmodule

[src/rope_rotate.sv]
// Rotation datapath: four registered products, then sum, round and saturate.
// Depends on rope_pkg. Produces one rotated pair per valid cycle.
module rope_rotate (
  input  logic                clk,
  input  logic                rst,
  input  rope_pkg::pair_ctl_t s1_ctl,
  input  logic signed [rope_pkg::DATA_WIDTH-1:0] s1_a,
  input  logic signed [rope_pkg::DATA_WIDTH-1:0] s1_x,
  input  logic signed [rope_pkg::TRIG_WIDTH-1:0] s1_sin,
  input  logic signed [rope_pkg::TRIG_WIDTH-1:0] s1_cos,
  output logic                   res_valid,
  output rope_pkg::result_pair_t res
);
  import rope_pkg::*;

  pair_ctl_t                    s2_ctl;
  logic signed [PROD_WIDTH-1:0] p_ac;
  logic signed [PROD_WIDTH-1:0] p_xs;
  logic signed [PROD_WIDTH-1:0] p_as;
  logic signed [PROD_WIDTH-1:0] p_xc;
  logic signed [SUM_WIDTH-1:0]  sum_first;
  logic signed [SUM_WIDTH-1:0]  sum_second;

  // Register the four products
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl.valid <= 1'b0;
    end else begin
      s2_ctl.valid <= s1_ctl.valid;
    end
    if (s1_ctl.valid) begin
      s2_ctl.first_idx  <= s1_ctl.first_idx;
      s2_ctl.second_idx <= s1_ctl.second_idx;
      s2_ctl.row_end    <= s1_ctl.row_end;
      p_ac <= s1_a * s1_cos;
      p_xs <= s1_x * s1_sin;
      p_as <= s1_a * s1_sin;
      p_xc <= s1_x * s1_cos;
    end
  end

  // Combine exactly, then round each result to the data width
  always_comb begin
    sum_first  = SUM_WIDTH'(p_ac) - SUM_WIDTH'(p_xs);
    sum_second = SUM_WIDTH'(p_as) + SUM_WIDTH'(p_xc);
    res.first_res.out_index  = INDEX_WIDTH'(s2_ctl.first_idx);
    res.first_res.out_value  = round_sat(sum_first);
    res.first_res.row_end    = 1'b0;
    res.second_res.out_index = INDEX_WIDTH'(s2_ctl.second_idx);
    res.second_res.out_value = round_sat(sum_second);
    res.second_res.row_end   = s2_ctl.row_end;
  end

  assign res_valid = s2_ctl.valid;

endmodule

[src/rope_out_fifo.sv]
// Result queue of rotated pairs and the serializer that sends one item per
// accept, first member then second. Depends on rope_pkg.
module rope_out_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  rope_pkg::result_pair_t push_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rope_pkg::out_item_t    out_data,
  output logic [rope_pkg::COUNT_WIDTH-1:0] count
);
  import rope_pkg::*;

  result_pair_t              entries [FIFO_DEPTH];
  logic [FIFO_PTR_WIDTH-1:0] wr_ptr;
  logic [FIFO_PTR_WIDTH-1:0] rd_ptr;
  logic                      phase;
  logic                      take;
  logic                      pop;
  result_pair_t              head;

  assign head      = entries[rd_ptr];
  assign out_valid = (count != '0);
  assign out_data  = phase ? head.second_res : head.first_res;
  assign take      = out_valid && out_ready;
  assign pop       = take && phase;

  // Write incoming pairs
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers, occupancy and the member select
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      phase  <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_WIDTH'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_WIDTH'(1);
      end
      if (take) begin
        phase <= ~phase;
      end
      count <= count + COUNT_WIDTH'(push) - COUNT_WIDTH'(pop);
    end
  end

endmodule

[bench/testbench.sv]
// Self-checking bench for rotary_position_embedding_top: directed pairs, then random vectors
// over many head_dim and pairing settings, each result checked against a local rotation model or a given value.
// Depends on rope_pkg and the RTL under src/.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rope_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 9;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int TRIG_ONE      = 1 << TRIG_FRAC_BITS;
  localparam int DIM_CEILING   = (1 << DIM_WIDTH) - 1;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = CFG_INDEX_WIDTH'(3);

  localparam longint ROUND_TIE = longint'(1) << (TRIG_FRAC_BITS - 1);
  localparam longint FRAC_MASK = (longint'(1) << TRIG_FRAC_BITS) - 1;
  localparam longint VALUE_MAX = (longint'(1) << (DATA_WIDTH - 1)) - 1;
  localparam longint VALUE_MIN = -VALUE_MAX - 1;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                    kind;
    logic [CFG_INDEX_WIDTH-1:0]   index;
    logic [CFG_DATA_WIDTH-1:0]    data;
    in_item_t                     item;
    logic                         typed;
    logic signed [DATA_WIDTH-1:0] first_val;
    logic signed [DATA_WIDTH-1:0] second_val;
  } plan_row_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  in_item_t                   in_data   = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  out_item_t                  out_data;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

  // Local copy of the block state
  logic [DIM_WIDTH-1:0]         dim_reg;
  logic                         mode_reg;
  logic signed [DATA_WIDTH-1:0] first_mem [SLOT_COUNT];
  int                           elem_pos;

  out_item_t rotated_due[$];
  plan_row_t plan[$];

  logic quiet      = 1'b0;
  int   stall_left = 0;
  int   cycles     = 0;
  int   mismatches = 0;
  int   n_items    = 0;
  int   n_results  = 0;
  int   n_rows     = 0;
  int   n_writes   = 0;

  rotary_position_embedding_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Clamp head_dim the way the block does: drop bit 0, floor at 2, cap at the maximum
  function automatic int eff_dim(logic [DIM_WIDTH-1:0] d);
    int hd;
    hd = int'(d) & ~1;
    if (hd < 2) hd = 2;
    if (hd > MAX_HEAD_DIM) hd = MAX_HEAD_DIM;
    return hd;
  endfunction

  // Shift out the fraction, round half to even, saturate
  function automatic logic signed [DATA_WIDTH-1:0] round_q14(longint v);
    longint q;
    longint rem;
    q   = v >>> TRIG_FRAC_BITS;
    rem = v & FRAC_MASK;
    if (rem > ROUND_TIE || (rem == ROUND_TIE && q[0])) q++;
    if (q > VALUE_MAX) q = VALUE_MAX;
    if (q < VALUE_MIN) q = VALUE_MIN;
    return DATA_WIDTH'(q);
  endfunction

  // Advance the element position; on a second member queue both rotated results
  task automatic rotate_pair(in_item_t it, logic typed,
                             logic signed [DATA_WIDTH-1:0] first_val,
                             logic signed [DATA_WIDTH-1:0] second_val);
    int        hd;
    int        half;
    int        c;
    int        first_idx;
    int        slot;
    logic      second;
    longint    a;
    longint    x;
    longint    s;
    longint    co;
    out_item_t r;
    hd   = eff_dim(dim_reg);
    half = hd / 2;
    c    = elem_pos;
    if (c >= hd) c = 0;
    if (mode_reg) begin
      second    = (c >= half);
      first_idx = second ? c - half : c;
    end else begin
      second    = c[0];
      first_idx = c & ~1;
    end
    elem_pos = (c + 1 >= hd) ? 0 : c + 1;
    slot     = mode_reg ? first_idx : first_idx >> 1;
    if (!second) begin
      first_mem[slot] = it.x_value;
    end else begin
      a  = first_mem[slot];
      x  = $signed(it.x_value);
      s  = $signed(it.sin_value);
      co = $signed(it.cos_value);
      r.out_index = INDEX_WIDTH'(first_idx);
      r.out_value = typed ? first_val : round_q14(a * co - x * s);
      r.row_end   = 1'b0;
      rotated_due.push_back(r);
      r.out_index = INDEX_WIDTH'(c);
      r.out_value = typed ? second_val : round_q14(a * s + x * co);
      r.row_end   = (c == hd - 1);
      rotated_due.push_back(r);
    end
  endtask

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 18) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [TRIG_WIDTH-1:0] rand_trig();
    case ($urandom_range(0, 19))
      0: return TRIG_WIDTH'(TRIG_ONE);
      1: return TRIG_WIDTH'(-TRIG_ONE);
      2: return '0;
      3: return TRIG_WIDTH'($urandom);
      default: return TRIG_WIDTH'(int'($urandom_range(0, 2 * TRIG_ONE)) - TRIG_ONE);
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    case ($urandom_range(0, 9))
      0: it.x_value = DATA_WIDTH'(VALUE_MAX);
      1: it.x_value = DATA_WIDTH'(VALUE_MIN);
      2: it.x_value = DATA_WIDTH'(int'($urandom_range(0, 8)) - 4);
      default: it.x_value = DATA_WIDTH'($urandom);
    endcase
    it.sin_value = rand_trig();
    it.cos_value = rand_trig();
    return it;
  endfunction

  task automatic plan_item(int x, int s, int c, logic typed = 1'b0, int v0 = 0, int v1 = 0);
    plan_row_t row;
    row                = '0;
    row.kind           = ROW_ITEM;
    row.item.x_value   = DATA_WIDTH'(x);
    row.item.sin_value = TRIG_WIDTH'(s);
    row.item.cos_value = TRIG_WIDTH'(c);
    row.typed          = typed;
    row.first_val      = DATA_WIDTH'(v0);
    row.second_val     = DATA_WIDTH'(v1);
    plan.push_back(row);
  endtask

  task automatic plan_write(logic [CFG_INDEX_WIDTH-1:0] idx, int data);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_WRITE;
    row.index = idx;
    row.data  = CFG_DATA_WIDTH'(data);
    plan.push_back(row);
  endtask

  // Offer one item, hold it until accepted, then maybe idle
  task automatic send_item(in_item_t it, logic typed = 1'b0,
                           logic signed [DATA_WIDTH-1:0] first_val = '0,
                           logic signed [DATA_WIDTH-1:0] second_val = '0);
    int gap;
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    rotate_pair(it, typed, first_val, second_val);
    n_items++;
    gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, drain every pending result, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (rotated_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == REG_HEAD_DIM) begin
      dim_reg = DIM_WIDTH'(data);
    end else if (idx == REG_PAIR_MODE) begin
      mode_reg = data[0];
    end
    elem_pos = 0;
    n_writes++;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stalls unless in a quiet stretch
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 6) == 0) stall_left <= idle_len();
    end
  end

  // Compare each accepted result with the oldest pending one
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (rotated_due.size() == 0) begin
        $display("%0t: unexpected result: index %0d value %0d row_end %0b", $time,
                 out_data.out_index, $signed(out_data.out_value), out_data.row_end);
        mismatches++;
      end else begin
        want = rotated_due.pop_front();
        n_results++;
        if (want.row_end) n_rows++;
        if (out_data.out_index !== want.out_index) begin
          $display("%0t: out_index expected %0d, got %0d", $time,
                   want.out_index, out_data.out_index);
          mismatches++;
        end
        if (out_data.out_value !== want.out_value) begin
          $display("%0t: out_value expected %0d, got %0d (index %0d)", $time,
                   $signed(want.out_value), $signed(out_data.out_value), want.out_index);
          mismatches++;
        end
        if (out_data.row_end !== want.row_end) begin
          $display("%0t: row_end expected %0b, got %0b (index %0d)", $time,
                   want.row_end, out_data.row_end, want.out_index);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles, rotated_due.size());
      $display("[rotary_position_embedding_top] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t row;
    int        phase;
    int        hd;
    int        count;
    int        dim;
    dim_reg  = HEAD_DIM_RESET;
    mode_reg = 1'b0;
    elem_pos = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: interleaved pairs, head_dim 128; saturation and rounding ties
    plan_item(1000, 5000, -7000);
    plan_item(2000, 0, TRIG_ONE, 1'b1, 1000, 2000);
    plan_item(32767, 5000, -7000);
    plan_item(-32768, TRIG_ONE, TRIG_ONE, 1'b1, 32767, -1);
    plan_item(-32768, 5000, -7000);
    plan_item(-32768, -TRIG_ONE, -TRIG_ONE, 1'b1, 0, 32767);
    plan_item(-32768, 5000, -7000);
    plan_item(32767, TRIG_ONE, -TRIG_ONE, 1'b1, 1, -32768);
    plan_item(1, 5000, -7000);
    plan_item(3, 0, TRIG_ONE / 2, 1'b1, 0, 2);
    plan_item(-1, 5000, -7000);
    plan_item(-3, 0, TRIG_ONE / 2, 1'b1, 0, -2);
    // Smallest vector, then head_dim below two
    plan_write(REG_HEAD_DIM, HEAD_DIM_MIN);
    plan_item(1234, 5000, 15000);
    plan_item(-777, -9000, 12000);
    plan_write(REG_HEAD_DIM, 0);
    plan_item(300, 0, 0);
    plan_item(400, TRIG_ONE, 0, 1'b1, -400, 300);
    // Half-split with an odd head_dim
    plan_write(REG_PAIR_MODE, 1);
    plan_write(REG_HEAD_DIM, 5);
    plan_item(100, 1, 2);
    plan_item(200, 3, 4);
    plan_item(300, 11585, 11585);
    plan_item(-400, -11585, 11585);
    // head_dim above the maximum, then abandon the vector with a spare-index write
    plan_write(REG_HEAD_DIM, DIM_CEILING);
    plan_item(-5, 3, 4);
    plan_write(REG_SPARE, 'h155);
    plan_write(REG_PAIR_MODE, 'h1FE);
    plan_item(21845, 10922, -10923);
    plan_item(-21846, -10923, 10922);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_WRITE) begin
        wait_idle();
        write_reg(row.index, row.data);
      end else begin
        send_item(row.item, row.typed, row.first_val, row.second_val);
      end
    end

    // Random phases: new settings between phases, mostly whole vectors
    for (phase = 0; n_items < plan.size() + RANDOM_ITEMS; phase++) begin
      wait_idle();
      if (phase == 0) begin
        write_reg(REG_HEAD_DIM, HEAD_DIM_MAX);
        write_reg(REG_PAIR_MODE, 1);
      end else if (phase == 1) begin
        write_reg(REG_PAIR_MODE, 0);
      end else begin
        if ($urandom_range(0, 4) != 0) begin
          case ($urandom_range(0, 29))
            0: dim = MAX_HEAD_DIM;
            1: dim = $urandom_range(MAX_HEAD_DIM + 1, DIM_CEILING);
            2: dim = $urandom_range(0, 1);
            3: dim = MAX_HEAD_DIM / 2;
            4, 5, 6, 7, 8, 9: dim = $urandom_range(2, 8);
            default: dim = $urandom_range(2, 40);
          endcase
          write_reg(REG_HEAD_DIM, CFG_DATA_WIDTH'(dim));
        end
        if ($urandom_range(0, 2) != 0) write_reg(REG_PAIR_MODE, CFG_DATA_WIDTH'($urandom));
        if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, CFG_DATA_WIDTH'($urandom));
      end
      hd    = eff_dim(dim_reg);
      count = (hd >= 64) ? hd : hd * $urandom_range(1, 4);
      if ($urandom_range(0, 9) < 3) count += $urandom_range(1, hd - 1);
      quiet <= ($urandom_range(0, 4) == 0);
      repeat (count) begin
        send_item(rand_item());
        if ($urandom_range(0, 199) == 0) wait_idle();
      end
    end

    wait_idle();
    $display("Sent %0d elements, %0d register writes; checked %0d results over %0d rows.",
             n_items, n_writes, n_results, n_rows);
    $display("Both pairing modes, head_dim 2..256 with odd and clamped settings, random stalls.");
    if (mismatches == 0 && rotated_due.size() == 0) begin
      $display("[rotary_position_embedding_top] OK");
    end else begin
      $display("[rotary_position_embedding_top] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
src/rope_pkg.sv
src/rope_pair_store.sv
src/rope_rotate.sv
src/rope_out_fifo.sv
src/rotary_position_embedding_top.sv
bench/testbench.sv
